>>> rtl/hlbc_pkg.sv
package hlbc_pkg;

    localparam logic [1:0] FN_GET     = 2'd0;
    localparam logic [1:0] FN_RELEASE = 2'd1;
    localparam logic [1:0] FN_PIN     = 2'd2;
    localparam logic [1:0] FN_UNPIN   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_COUNT  = 2'd2;

    localparam logic [7:0] COUNT_MAX = 8'd255;

    // per-slot tag and reference count as kept in the tag memory
    typedef struct packed {
        logic [7:0]  dev;
        logic [31:0] blk;
        logic [7:0]  cnt;
    } t_tag;

    localparam int TAG_W = $bits(t_tag);

    typedef struct packed {
        logic [4:0] slot_out;
        logic       hit;
        logic       need_fill;
        logic [1:0] status;
    } t_rsp;

endpackage

>>> rtl/hlbc_req_if.sv
interface hlbc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  device;
    logic [31:0] block_number;
    logic [4:0]  slot_in;

    modport source (output valid, func, device, block_number, slot_in, input ready);
    modport sink   (input valid, func, device, block_number, slot_in, output ready);
endinterface

>>> rtl/hlbc_rsp_if.sv
interface hlbc_rsp_if;
    logic       valid;
    logic       ready;
    logic [4:0] slot_out;
    logic       hit;
    logic       need_fill;
    logic [1:0] status;

    modport source (output valid, slot_out, hit, need_fill, status, input ready);
    modport sink   (input valid, slot_out, hit, need_fill, status, output ready);
endinterface

>>> rtl/hashed_lru_buffer_cache_top.sv
// Buffer cache tag manager. One request is taken at a time; i_req.ready is
// high only while the block is idle, and the result waits in an output
// register. Pin and unpin, like a release that leaves a nonzero count, read
// the slot's tag and update its count unless the count check fails; a slot
// out of range is answered without a tag read. A get, and a release that
// drops the count to zero, first find the bucket (from the block number or
// from the slot) by a 4-step byte-serial modulo unit; then the bucket's
// slots, at most NUM_SLOTS / NUM_BUCKETS rounded up, are walked one per
// cycle through the single read port of the tag memory. A result held by
// the sink stalls the block until the output register is free.
module hashed_lru_buffer_cache_top #(
    parameter int NUM_SLOTS   = 30,
    parameter int NUM_BUCKETS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hlbc_req_if.sink    i_req,
    hlbc_rsp_if.source  o_rsp
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int RANK_W = SLOT_W;
    localparam int PTR_W  = $clog2(NUM_SLOTS + NUM_BUCKETS);
    localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int EXT_W  = SLOT_W + 6;
    localparam int RAM_W  = RANK_W + hlbc_pkg::TAG_W;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CHK  = 7'b0000010,
        S_MOD  = 7'b0000100,
        S_SCAN = 7'b0001000,
        S_UPD  = 7'b0010000,
        S_PUT  = 7'b0100000,
        S_HOLD = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [1:0]        r_func;
    logic [7:0]        r_dev;
    logic [31:0]       r_blk;
    logic [4:0]        r_slot;
    logic [SLOT_W-1:0] r_sidx;

    logic [PTR_W-1:0]  r_ptr;
    logic              r_pend;
    logic [SLOT_W-1:0] r_paddr;

    logic              r_fnd;
    logic [SLOT_W-1:0] r_bidx;
    logic [RANK_W-1:0] r_brank;
    logic [7:0]        r_bcnt;
    logic              r_vfnd;
    logic [SLOT_W-1:0] r_vidx;
    logic [RANK_W-1:0] r_vrank;

    hlbc_pkg::t_tag    r_ent;
    logic [RANK_W-1:0] r_rank;
    hlbc_pkg::t_rsp    r_res;
    hlbc_pkg::t_rsp    r_out;
    logic              r_ovalid;

    logic r_touch [NUM_SLOTS];
    logic r_cval  [NUM_SLOTS];

    logic [RANK_W-1:0] w_rst_rank [NUM_SLOTS];

    logic              w_acc;
    logic              w_is_get;
    logic              w_is_rel;
    logic              w_oor;
    logic              w_ptr_in;
    logic              w_out_free;
    logic [RAM_W-1:0]  w_q;
    hlbc_pkg::t_tag    w_rd;
    logic [RANK_W-1:0] w_rd_rank;
    logic              w_match;
    logic              w_cnt_err;
    logic              w_rel_zero;

    logic              w_we;
    logic [SLOT_W-1:0] w_waddr;
    logic [RAM_W-1:0]  w_wdata;
    logic [SLOT_W-1:0] w_raddr;

    logic              w_mod_start;
    logic [31:0]       w_mod_val;
    logic              w_mod_done;
    logic [BKT_W-1:0]  w_mod_rem;

    // recency at reset: higher slot index is more recent within its bucket
    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_rst_rank
        assign w_rst_rank[g] = RANK_W'((NUM_SLOTS - g % NUM_BUCKETS + NUM_BUCKETS - 1)
                                       / NUM_BUCKETS - 1 - g / NUM_BUCKETS);
    end

    assign w_acc      = i_req.valid && (r_state == S_IDLE);
    assign w_is_get   = (r_func == hlbc_pkg::FN_GET);
    assign w_is_rel   = (r_func == hlbc_pkg::FN_RELEASE);
    assign w_oor      = (EXT_W'(i_req.slot_in) >= EXT_W'(NUM_SLOTS));
    assign w_ptr_in   = (r_ptr < PTR_W'(NUM_SLOTS));
    assign w_out_free = !r_ovalid || o_rsp.ready;

    // slots never written read back as their reset contents
    assign w_rd      = r_touch[r_paddr] ? hlbc_pkg::t_tag'(w_q[hlbc_pkg::TAG_W-1:0]) : '0;
    assign w_rd_rank = r_touch[r_paddr] ? w_q[RAM_W-1 -: RANK_W] : w_rst_rank[r_paddr];
    assign w_match   = (w_rd.dev == r_dev) && (w_rd.blk == r_blk);

    assign w_cnt_err  = (r_func == hlbc_pkg::FN_PIN) ? (w_rd.cnt == hlbc_pkg::COUNT_MAX)
                                                     : (w_rd.cnt == 8'd0);
    assign w_rel_zero = w_is_rel && (w_rd.cnt == 8'd1);

    assign w_mod_start = (w_acc && (i_req.func == hlbc_pkg::FN_GET))
                      || ((r_state == S_CHK) && w_rel_zero);
    assign w_mod_val   = (r_state == S_IDLE) ? i_req.block_number : 32'(r_slot);
    assign w_raddr     = (r_state == S_IDLE) ? SLOT_W'(i_req.slot_in) : r_ptr[SLOT_W-1:0];

    hlbc_bkt_mod #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .BKT_W       (BKT_W)
    ) u_bkt_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_value (w_mod_val),
        .o_done  (w_mod_done),
        .o_rem   (w_mod_rem)
    );

    hlbc_ram #(
        .WIDTH (RAM_W),
        .DEPTH (NUM_SLOTS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    // tag memory write port
    always_comb begin
        hlbc_pkg::t_tag t;
        t       = w_rd;
        w_we    = 1'b0;
        w_waddr = r_paddr;
        w_wdata = {w_rd_rank, w_rd};
        unique case (r_state)
            S_CHK: begin
                if (!w_cnt_err && !w_rel_zero) begin
                    w_we  = 1'b1;
                    t.cnt = (r_func == hlbc_pkg::FN_PIN) ? w_rd.cnt + 8'd1 : w_rd.cnt - 8'd1;
                    w_wdata = {w_rd_rank, t};
                end
            end
            S_SCAN: begin
                // release to zero: every more recent slot in the bucket ages by one
                if (w_is_rel && r_pend && (r_paddr != r_sidx) && (w_rd_rank < r_rank)) begin
                    w_we    = 1'b1;
                    w_wdata = {w_rd_rank + RANK_W'(1), w_rd};
                end
            end
            S_UPD: begin
                if (w_is_get) begin
                    t.dev = r_dev;
                    t.blk = r_blk;
                    if (r_fnd) begin
                        w_we    = (r_bcnt != hlbc_pkg::COUNT_MAX);
                        w_waddr = r_bidx;
                        t.cnt   = r_bcnt + 8'd1;
                        w_wdata = {r_brank, t};
                    end else begin
                        w_we    = r_vfnd;
                        w_waddr = r_vidx;
                        t.cnt   = 8'd1;
                        w_wdata = {r_vrank, t};
                    end
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_sidx;
                    t       = r_ent;
                    t.cnt   = 8'd0;
                    w_wdata = {RANK_W'(0), t};
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_req.func == hlbc_pkg::FN_GET) begin
                        n_state = S_MOD;
                    end else if (w_oor) begin
                        n_state = S_PUT;
                    end else begin
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK:  n_state = (!w_cnt_err && w_rel_zero) ? S_MOD : S_PUT;
            S_MOD:  n_state = w_mod_done ? S_SCAN : S_MOD;
            S_SCAN: n_state = (!r_pend && !w_ptr_in) ? S_UPD : S_SCAN;
            S_UPD:  n_state = S_PUT;
            S_PUT:  n_state = w_out_free ? S_IDLE : S_HOLD;
            S_HOLD: n_state = w_out_free ? S_IDLE : S_HOLD;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_touch[s] <= 1'b0;
                r_cval[s]  <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (w_we) begin
                r_touch[w_waddr] <= 1'b1;
            end
            if (((r_state == S_PUT) || (r_state == S_HOLD)) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == S_MOD) begin
                r_pend <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_pend <= w_ptr_in;
            end
            if ((r_state == S_UPD) && w_is_get && w_we) begin
                r_cval[w_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (((r_state == S_PUT) || (r_state == S_HOLD)) && w_out_free) begin
            r_out <= r_res;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    r_func  <= i_req.func;
                    r_dev   <= i_req.device;
                    r_blk   <= i_req.block_number;
                    r_slot  <= i_req.slot_in;
                    r_sidx  <= SLOT_W'(i_req.slot_in);
                    r_paddr <= SLOT_W'(i_req.slot_in);
                    r_res   <= '{i_req.slot_in, 1'b0, 1'b0, hlbc_pkg::ST_COUNT};
                end
            end
            S_CHK: begin
                r_ent  <= w_rd;
                r_rank <= w_rd_rank;
                r_res  <= '{r_slot, 1'b0, 1'b0,
                            w_cnt_err ? hlbc_pkg::ST_COUNT : hlbc_pkg::ST_OK};
            end
            S_MOD: begin
                r_ptr  <= PTR_W'(w_mod_rem);
                r_fnd  <= 1'b0;
                r_vfnd <= 1'b0;
            end
            S_SCAN: begin
                if (w_ptr_in) begin
                    r_paddr <= r_ptr[SLOT_W-1:0];
                    r_ptr   <= r_ptr + PTR_W'(NUM_BUCKETS);
                end
                if (r_pend && w_is_get) begin
                    // most recent matching tag, least recent free slot
                    if (w_match && (!r_fnd || (w_rd_rank < r_brank))) begin
                        r_fnd   <= 1'b1;
                        r_bidx  <= r_paddr;
                        r_brank <= w_rd_rank;
                        r_bcnt  <= w_rd.cnt;
                    end
                    if ((w_rd.cnt == 8'd0) && (!r_vfnd || (w_rd_rank > r_vrank))) begin
                        r_vfnd  <= 1'b1;
                        r_vidx  <= r_paddr;
                        r_vrank <= w_rd_rank;
                    end
                end
            end
            S_UPD: begin
                if (!w_is_get) begin
                    r_res <= '{r_slot, 1'b0, 1'b0, hlbc_pkg::ST_OK};
                end else if (r_fnd) begin
                    r_res <= '{5'(r_bidx), 1'b1, !r_cval[r_bidx],
                               (r_bcnt == hlbc_pkg::COUNT_MAX) ? hlbc_pkg::ST_COUNT
                                                               : hlbc_pkg::ST_OK};
                end else if (r_vfnd) begin
                    r_res <= '{5'(r_vidx), 1'b0, 1'b1, hlbc_pkg::ST_OK};
                end else begin
                    r_res <= '{5'd0, 1'b0, 1'b0, hlbc_pkg::ST_NOFREE};
                end
            end
            default: begin
            end
        endcase
    end

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_ovalid;
    assign o_rsp.slot_out  = r_out.slot_out;
    assign o_rsp.hit       = r_out.hit;
    assign o_rsp.need_fill = r_out.need_fill;
    assign o_rsp.status    = r_out.status;

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_we)
        else $error("tag memory written while idle");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && r_pend) |-> (EXT_W'(r_paddr) < EXT_W'(NUM_SLOTS)))
        else $error("scan address past last slot");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_state != S_IDLE))
        else $error("request accepted without leaving idle");

    a_nofree_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_out.status == hlbc_pkg::ST_NOFREE))
            |-> (!r_out.hit && !r_out.need_fill && (r_out.slot_out == 5'd0)))
        else $error("no-free result carries slot data");

endmodule

>>> rtl/hlbc_ram.sv
module hlbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/hlbc_bkt_mod.sv
module hlbc_bkt_mod #(
    parameter int NUM_BUCKETS = 3,
    parameter int BKT_W       = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [31:0]      i_value,
    output logic             o_done,
    output logic [BKT_W-1:0] o_rem
);

    localparam int ACC_W = BKT_W + 8;

    logic             r_busy;
    logic             r_done;
    logic [1:0]       r_cnt;
    logic [31:0]      r_val;
    logic [BKT_W-1:0] r_acc;
    logic [BKT_W-1:0] n_acc;

    // one byte per step: fold the next byte into the remainder, then
    // restoring subtraction of the bucket count shifted down from 7
    always_comb begin
        logic [ACC_W-1:0] a;
        a = {r_acc, r_val[31:24]};
        for (int k = 7; k >= 0; k--) begin
            if (a >= (ACC_W'(NUM_BUCKETS) << k)) begin
                a = a - (ACC_W'(NUM_BUCKETS) << k);
            end
        end
        n_acc = a[BKT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 2'd1;
            if (r_cnt == 2'd3) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
            r_acc <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[23:0], 8'd0};
            r_acc <= n_acc;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_acc;

endmodule
